// ===== rtl/msbs_pkg.sv =====
// Shared types, constants and helpers for the masked byte signature scanner.
`default_nettype none

package msbs_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int IDX_W = $clog2(MAX_PATTERN);
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SCAN   = 2'd1,
    ACT_FINISH = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_UNIQUE    = 3'd0,
    ST_KNOWN     = 3'd1,
    ST_AMBIGUOUS = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_CONFLICT  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_LENGTH = 2'd0,
    CFG_MASKED = 2'd1,
    CFG_POLICY = 2'd2,
    CFG_KNOWN  = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    POL_UNIQUE = 2'd0,
    POL_KNOWN  = 2'd1,
    POL_VERIFY = 2'd2,
    POL_SPARE  = 2'd3
  } policy_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] addr;
    logic [1:0]  count;
  } report_t;

  function automatic logic [LEN_W-1:0] active_length(input logic [5:0] len);
    logic [LEN_W-1:0] res;
    if (len == 6'd0) begin
      res = LEN_W'(1);
    end else if (32'(len) > MAX_PATTERN) begin
      res = LEN_W'(MAX_PATTERN);
    end else begin
      res = LEN_W'(len);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/msbs_cell.sv =====
// One scanner cell: a pattern byte with its mask and one byte of the sliding window.
`default_nettype none

module msbs_cell
  import msbs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       load_en,
  input  wire logic [7:0] load_pattern,
  input  wire logic [7:0] load_mask,
  input  wire logic       shift_en,
  input  wire logic [7:0] win_in,
  input  wire logic [7:0] cmp_byte,
  input  wire logic       masked_enable,
  input  wire logic       active,
  output logic      [7:0] win,
  output logic            hit
);

  logic [7:0] pattern;
  logic [7:0] mask;
  logic [7:0] eff_mask;

  always_ff @(posedge clk) begin
    if (load_en) begin
      pattern <= load_pattern;
      mask    <= load_mask;
    end
    if (shift_en) begin
      win <= win_in;
    end
  end

  assign eff_mask = masked_enable ? mask : 8'hff;
  assign hit = !active || ((cmp_byte & eff_mask) == (pattern & eff_mask));

endmodule

`default_nettype wire

// ===== rtl/msbs_tally.sv =====
// Match counting, hit address capture and the verdict under the match policy.
`default_nettype none

module msbs_tally
  import msbs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             match,
  input  wire logic             finish,
  input  wire logic [31:0]      byte_address,
  input  wire logic [LEN_W-1:0] len_eff,
  input  wire logic [31:0]      known_address,
  input  wire logic [1:0]       match_policy,
  output report_t               report
);

  logic [1:0]  hit_count;
  logic [31:0] first_hit;
  logic [31:0] second_hit;
  logic        known_seen;
  logic [31:0] start_addr;

  assign start_addr = byte_address - (32'(len_eff) - 32'd1);

  always_ff @(posedge clk) begin
    if (rst || finish) begin
      hit_count  <= 2'd0;
      first_hit  <= 32'd0;
      second_hit <= 32'd0;
      known_seen <= 1'b0;
    end else if (match) begin
      if (start_addr == known_address) begin
        known_seen <= 1'b1;
      end
      if (hit_count == 2'd0) begin
        first_hit <= start_addr;
        hit_count <= 2'd1;
      end else if (hit_count == 2'd1) begin
        second_hit <= start_addr;
        hit_count  <= 2'd2;
      end
    end
  end

  always_comb begin
    if (match_policy != POL_UNIQUE && !known_seen) begin
      report = '{status: ST_CONFLICT, addr: 32'd0, count: 2'd0};
    end else if (match_policy == POL_KNOWN) begin
      report = '{status: ST_KNOWN, addr: known_address, count: 2'd1};
    end else if (hit_count == 2'd1) begin
      report = '{status: ST_UNIQUE, addr: first_hit, count: 2'd1};
    end else if (hit_count == 2'd2) begin
      report = '{status: ST_AMBIGUOUS, addr: second_hit, count: 2'd2};
    end else begin
      report = '{status: ST_NOT_FOUND, addr: 32'd0, count: 2'd0};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/masked_byte_signature_scanner.sv =====
// Top level of the masked byte signature scanner: cell chain, tally and result register.
//
// Usage: registers are written through cfg_we, cfg_index and cfg_data while the block is
// idle. Input transactions carry an action. A load writes one pattern byte and its mask into
// the cell at pattern_index. A scan shifts data_byte into the window held across the cell
// row; every cell compares its pattern byte against the aligned window byte in the same
// cycle, and a full match updates the match count and hit addresses. section_start empties
// the window before its byte enters. A finish produces one result transaction with status,
// match_address and match_count, then clears the scan state.
// Throughput is one input transaction per cycle while in_stall is low, with a parallel compare
// across the cell row. The result of a finish appears on out_valid in the cycle after the
// finish transaction is accepted. The result register holds its transaction while out_stall
// is high; loads and scans are still taken, and only a further finish waits on in_stall.
// A synchronous reset restores the register defaults and clears the window fill, counts and
// result valid; pattern and mask bytes are undefined until loaded.
`default_nettype none

module masked_byte_signature_scanner
  import msbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  action,
  input  wire logic [4:0]  pattern_index,
  input  wire logic [7:0]  pattern_byte,
  input  wire logic [7:0]  mask_byte,
  input  wire logic [7:0]  data_byte,
  input  wire logic [31:0] byte_address,
  input  wire logic        section_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [2:0]  status,
  output logic      [31:0] match_address,
  output logic      [1:0]  match_count
);

  logic [5:0]  pattern_length;
  logic        masked_enable;
  logic [1:0]  match_policy;
  logic [31:0] known_address;

  logic             accept;
  logic             do_load;
  logic             do_scan;
  logic             do_finish;
  logic [LEN_W-1:0] len_eff;
  logic [IDX_W-1:0] len_m1;
  logic [LEN_W-1:0] fill;
  logic [LEN_W-1:0] fill_base;
  logic [LEN_W-1:0] fill_next;
  logic             match;
  report_t          report;

  logic [7:0]             win      [MAX_PATTERN];
  logic [7:0]             win_next [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hits;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= 6'd1;
      masked_enable  <= 1'b0;
      match_policy   <= POL_UNIQUE;
      known_address  <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_LENGTH: pattern_length <= cfg_data[5:0];
        CFG_MASKED: masked_enable  <= cfg_data[0];
        CFG_POLICY: match_policy   <= cfg_data[1:0];
        CFG_KNOWN:  known_address  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall  = out_valid && out_stall && (action == ACT_FINISH);
  assign accept    = in_valid && !in_stall;
  assign do_load   = accept && (action == ACT_LOAD);
  assign do_scan   = accept && (action == ACT_SCAN);
  assign do_finish = accept && (action == ACT_FINISH);

  assign len_eff = active_length(pattern_length);
  assign len_m1  = IDX_W'(len_eff - LEN_W'(1));

  always_comb begin
    fill_base = section_start ? '0 : fill;
    if (32'(fill_base) >= MAX_PATTERN) begin
      fill_next = LEN_W'(MAX_PATTERN);
    end else begin
      fill_next = fill_base + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || do_finish) begin
      fill <= '0;
    end else if (do_scan) begin
      fill <= fill_next;
    end
  end

  always_comb begin
    win_next[0] = data_byte;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_next[i] = section_start ? 8'd0 : win[i-1];
    end
  end

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    logic [IDX_W-1:0] sel;
    logic             active;
    assign active = IDX_W'(g) <= len_m1;
    assign sel    = len_m1 - IDX_W'(g);
    msbs_cell u_cell (
      .clk           (clk),
      .load_en       (do_load && (pattern_index == IDX_W'(g))),
      .load_pattern  (pattern_byte),
      .load_mask     (mask_byte),
      .shift_en      (do_scan),
      .win_in        (win_next[g]),
      .cmp_byte      (win_next[sel]),
      .masked_enable (masked_enable),
      .active        (active),
      .win           (win[g]),
      .hit           (hits[g])
    );
  end

  assign match = do_scan && (fill_next >= len_eff) && (&hits);

  msbs_tally u_tally (
    .clk           (clk),
    .rst           (rst),
    .match         (match),
    .finish        (do_finish),
    .byte_address  (byte_address),
    .len_eff       (len_eff),
    .known_address (known_address),
    .match_policy  (match_policy),
    .report        (report)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_finish) begin
      status        <= report.status;
      match_address <= report.addr;
      match_count   <= report.count;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/scanner_checker.sv =====
// Checker for the masked byte signature scanner: predicts each verdict and compares results.
`timescale 1ns / 100ps

module scanner_checker
  import msbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  action,
  input  logic [4:0]  pattern_index,
  input  logic [7:0]  pattern_byte,
  input  logic [7:0]  mask_byte,
  input  logic [7:0]  data_byte,
  input  logic [31:0] byte_address,
  input  logic        section_start,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  status,
  input  logic [31:0] match_address,
  input  logic [1:0]  match_count,
  output int          fail_count,
  output int          reports_pending
);

  logic [7:0]  sig_bytes [MAX_PATTERN];
  logic [7:0]  sig_masks [MAX_PATTERN];
  logic [7:0]  recent [MAX_PATTERN];
  int unsigned fill;
  logic [1:0]  hits;
  logic [31:0] first_at;
  logic [31:0] second_at;
  bit          known_seen;

  logic [5:0]  len_reg;
  logic        masked_reg;
  policy_t     policy_reg;
  logic [31:0] known_reg;

  report_t     verdicts [$];
  report_t     want;
  int          mismatches = 0;

  task automatic clear_scan();
    int k;
    for (k = 0; k < MAX_PATTERN; k++) begin
      recent[k] = 8'd0;
    end
    fill = 0;
    hits = 2'd0;
    first_at = 32'd0;
    second_at = 32'd0;
    known_seen = 1'b0;
  endtask

  task automatic take_byte(input logic [7:0] b, input logic [31:0] addr, input logic opens);
    int unsigned n;
    int k;
    logic [7:0] m;
    logic [31:0] at;
    bit hit;
    n = len_reg;
    if (n == 0) n = 1;
    if (n > MAX_PATTERN) n = MAX_PATTERN;
    if (opens) begin
      for (k = 0; k < MAX_PATTERN; k++) begin
        recent[k] = 8'd0;
      end
      fill = 0;
    end
    for (k = MAX_PATTERN - 1; k > 0; k--) begin
      recent[k] = recent[k - 1];
    end
    recent[0] = b;
    if (fill < MAX_PATTERN) fill++;
    if (fill >= n) begin
      hit = 1'b1;
      for (k = 0; k < n; k++) begin
        m = masked_reg ? sig_masks[k] : 8'hff;
        if ((recent[n - 1 - k] & m) != (sig_bytes[k] & m)) hit = 1'b0;
      end
      if (hit) begin
        at = addr - 32'(n - 1);
        if (at == known_reg) known_seen = 1'b1;
        if (hits == 2'd0) begin
          first_at = at;
          hits = 2'd1;
        end else if (hits == 2'd1) begin
          second_at = at;
          hits = 2'd2;
        end
      end
    end
  endtask

  task automatic predict_verdict();
    report_t r;
    if (policy_reg != POL_UNIQUE && !known_seen) begin
      r.status = ST_CONFLICT;
      r.addr = 32'd0;
      r.count = 2'd0;
    end else if (policy_reg == POL_KNOWN) begin
      r.status = ST_KNOWN;
      r.addr = known_reg;
      r.count = 2'd1;
    end else if (hits == 2'd1) begin
      r.status = ST_UNIQUE;
      r.addr = first_at;
      r.count = 2'd1;
    end else if (hits == 2'd2) begin
      r.status = ST_AMBIGUOUS;
      r.addr = second_at;
      r.count = 2'd2;
    end else begin
      r.status = ST_NOT_FOUND;
      r.addr = 32'd0;
      r.count = 2'd0;
    end
    verdicts.insert(verdicts.size(), r);
    clear_scan();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      len_reg = 6'd1;
      masked_reg = 1'b0;
      policy_reg = POL_UNIQUE;
      known_reg = 32'd0;
      verdicts.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (verdicts.size() == 0) begin
          $error("unexpected result transaction: status %0d, match_address %h, match_count %0d",
                 status, match_address, match_count);
          mismatches++;
        end else begin
          want = verdicts.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            mismatches++;
          end
          if (match_address !== want.addr) begin
            $error("match_address: expected %h, actual %h", want.addr, match_address);
            mismatches++;
          end
          if (match_count !== want.count) begin
            $error("match_count: expected %0d, actual %0d", want.count, match_count);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_LENGTH: len_reg = cfg_data[5:0];
          CFG_MASKED: masked_reg = cfg_data[0];
          CFG_POLICY: policy_reg = policy_t'(cfg_data[1:0]);
          CFG_KNOWN:  known_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (action)
          ACT_LOAD: begin
            sig_bytes[pattern_index] = pattern_byte;
            sig_masks[pattern_index] = mask_byte;
          end
          ACT_SCAN:   take_byte(data_byte, byte_address, section_start);
          ACT_FINISH: predict_verdict();
          default: ;
        endcase
      end
    end
    fail_count <= mismatches;
    reports_pending <= verdicts.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the scanner testbench: clock, reset, stimulus, result stalls, watchdog and verdict.
`timescale 1ns / 100ps

module testbench;
  import msbs_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int QUIET_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_data = 32'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = 2'd0;
  logic [4:0]  pattern_index = 5'd0;
  logic [7:0]  pattern_byte = 8'd0;
  logic [7:0]  mask_byte = 8'd0;
  logic [7:0]  data_byte = 8'd0;
  logic [31:0] byte_address = 32'd0;
  logic        section_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [31:0] match_address;
  logic [1:0]  match_count;
  int          fail_count;
  int          reports_pending;

  logic [7:0]  pat_sh [MAX_PATTERN];
  logic [7:0]  msk_sh [MAX_PATTERN];
  int unsigned cur_len = 1;
  logic        cur_masked = 1'b0;
  logic [31:0] known_at = 32'd0;
  logic [31:0] sec_addr = 32'd0;
  logic        sec_open = 1'b0;
  bit          no_idle = 1'b0;
  bit          more_in_phase = 1'b0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          long_holds = 0;
  int          quiet = 0;

  masked_byte_signature_scanner dut (.*);
  scanner_checker u_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] act, input logic [4:0] idx, input logic [7:0] pb,
                           input logic [7:0] mb, input logic [7:0] db, input logic [31:0] addr,
                           input logic ss);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    pattern_index <= idx;
    pattern_byte <= pb;
    mask_byte <= mb;
    data_byte <= db;
    byte_address <= addr;
    section_start <= ss;
    do @(posedge clk); while (in_stall);
    if (act != ACT_NONE) items_sent++;
  endtask

  task automatic load_entry(input logic [4:0] idx, input logic [7:0] pb, input logic [7:0] mb);
    pat_sh[idx] = pb;
    msk_sh[idx] = mb;
    push_item(ACT_LOAD, idx, pb, mb, 8'($urandom), $urandom, 1'($urandom));
  endtask

  task automatic scan_item(input logic [7:0] db, input logic [31:0] addr, input logic ss);
    push_item(ACT_SCAN, 5'($urandom), 8'($urandom), 8'($urandom), db, addr, ss);
  endtask

  task automatic finish_item();
    push_item(ACT_FINISH, 5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), $urandom,
              1'($urandom));
  endtask

  task automatic noise_item();
    push_item(ACT_NONE, 5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), $urandom,
              1'($urandom));
  endtask

  task automatic open_section(input logic [31:0] base);
    sec_addr = base;
    sec_open = 1'b1;
  endtask

  task automatic emit(input logic [7:0] b);
    scan_item(b, sec_addr, sec_open);
    sec_addr = sec_addr + 32'd1;
    sec_open = 1'b0;
  endtask

  // Sends the leading bytes of a pattern occurrence; bits outside the mask are random.
  task automatic plant(input int unsigned upto);
    int unsigned k;
    logic [7:0] m;
    for (k = 0; k < upto; k++) begin
      m = cur_masked ? msk_sh[k] : 8'hff;
      emit((pat_sh[k] & m) | (8'($urandom) & ~m));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic configure(input logic [5:0] len, input logic masked, input policy_t pol,
                           input logic [31:0] known);
    drain();
    write_reg(CFG_LENGTH, {26'($urandom), len});
    write_reg(CFG_MASKED, {31'($urandom), masked});
    write_reg(CFG_POLICY, {30'($urandom), pol});
    write_reg(CFG_KNOWN, known);
    cfg_we <= 1'b0;
    cur_len = (len == 0) ? 1 : (len > MAX_PATTERN) ? MAX_PATTERN : len;
    cur_masked = masked;
    known_at = known;
  endtask

  task automatic random_phase();
    int unsigned pick, runs, run, sections, s, seg, pos, aim_at, cut;
    logic [5:0] len;
    bit aimed;
    pick = $urandom_range(0, 9);
    if (pick <= 5) len = 6'($urandom_range(1, 6));
    else if (pick == 6) len = 6'($urandom_range(7, 31));
    else if (pick == 7) len = 6'd32;
    else if (pick == 8) len = 6'd0;
    else len = 6'($urandom_range(33, 63));
    pick = $urandom_range(0, 3);
    configure(len, 1'($urandom), policy_t'($urandom_range(0, 3)),
              (pick == 0) ? 32'd0 : (pick == 1) ? 32'hffff_ffff : $urandom);
    no_idle = ($urandom_range(0, 4) == 0);
    runs = $urandom_range(1, 3);
    for (run = 0; run < runs; run++) begin
      sections = $urandom_range(1, 3);
      for (s = 0; s < sections; s++) begin
        aimed = ($urandom_range(0, 2) == 0);
        aim_at = $urandom_range(0, 5);
        if (aimed) open_section(known_at - aim_at);
        else if ($urandom_range(0, 3) == 0) open_section(32'hffff_fff0 + $urandom_range(0, 15));
        else open_section($urandom);
        seg = $urandom_range(3, 20);
        pos = 0;
        while (pos < seg) begin
          if (aimed && pos == aim_at) begin
            plant(cur_len);
            pos += cur_len;
          end else begin
            pick = $urandom_range(0, 11);
            case (pick)
              0: begin
                plant(cur_len);
                pos += cur_len;
              end
              1: begin
                cut = $urandom_range(1, cur_len);
                plant(cut);
                pos += cut;
              end
              2: noise_item();
              3: begin
                sec_open = 1'b1;
                emit(8'($urandom));
                pos++;
              end
              4: load_entry(5'($urandom), 8'($urandom), 8'($urandom));
              default: begin
                emit($urandom_range(0, 1) ? pat_sh[$urandom_range(0, 31)] : 8'($urandom));
                pos++;
              end
            endcase
          end
        end
      end
      more_in_phase = (run + 1 < runs);
      finish_item();
    end
  endtask

  initial begin
    int unsigned hold;
    while (rst) @(posedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 18);
      if (!no_idle && long_holds < 2 && results_seen >= 10 + 20 * long_holds && hold == 0) begin
        hold = 1;
      end
      if (hold == 0) begin
        out_stall <= 1'b0;
        do @(posedge clk); while (!out_valid);
      end else begin
        out_stall <= 1'b1;
        do @(posedge clk); while (!out_valid);
        // Hold the result long enough that a following finish backs up the input side.
        if (!no_idle && more_in_phase && long_holds < 2 &&
            results_seen >= 10 + 20 * long_holds) begin
          hold = 4000;
          long_holds++;
        end
        repeat (hold - 1) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end
      results_seen++;
    end
  end

  initial begin
    int i;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < MAX_PATTERN; i++) begin
      if (i == 0) load_entry(5'(i), 8'hff, 8'hff);
      else if (i == MAX_PATTERN - 1) load_entry(5'(i), 8'h00, 8'h00);
      else load_entry(5'(i), 8'($urandom), 8'($urandom));
    end

    // A zero length acts as one; the third match is past saturation and the address wraps.
    configure(6'd0, 1'b0, POL_UNIQUE, 32'd0);
    open_section(32'hffff_fffe);
    emit(8'hff);
    emit(8'h00);
    emit(8'hff);
    noise_item();
    emit(8'hff);
    finish_item();
    finish_item();

    configure(6'd2, 1'b1, POL_KNOWN, 32'h8000_0000);
    open_section(32'h8000_0000);
    plant(2);
    finish_item();

    // The section flag empties the window, so a split occurrence gives a conflict.
    configure(6'd2, 1'b1, POL_SPARE, 32'h0000_1234);
    open_section(32'h0000_1233);
    plant(1);
    open_section(32'h0000_1234);
    emit((pat_sh[1] & msk_sh[1]) | (8'($urandom) & ~msk_sh[1]));
    finish_item();

    configure(6'd2, 1'b0, POL_VERIFY, 32'hffff_ffff);
    open_section(32'hffff_ffff);
    plant(2);
    plant(2);
    finish_item();

    while (items_sent < 700) random_phase();

    drain();
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== masked_byte_signature_scanner.f =====
rtl/msbs_pkg.sv
rtl/msbs_cell.sv
rtl/msbs_tally.sv
rtl/masked_byte_signature_scanner.sv
tb/sv/scanner_checker.sv
tb/sv/testbench.sv
